>>> sv/bdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_PRESSED    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_TICKS     = 2'd2;

   localparam logic        LOW_PRESSED_RESET    = 1'b1;
   localparam logic [7:0]  DEBOUNCE_TICKS_RESET = 8'd5;
   localparam logic [15:0] LONG_TICKS_RESET     = 16'd100;

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_SEED = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } press_event_type;

   typedef struct packed {
      logic        low_pressed;
      logic [7:0]  debounce_ticks;
      logic [15:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic is_held;
      logic long_done;
   } hold_status_type;

endpackage

>>> sv/bdpc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdpc_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic pin_level;

   modport source (output valid, output opcode, output pin_level, input ready);
   modport sink (input valid, input opcode, input pin_level, output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_event;

   modport source (output valid, output press_event, input ready);
   modport sink (input valid, input press_event, output ready);
endinterface

`default_nettype wire

>>> sv/bdpc_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module bdpc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [bdpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bdpc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bdpc_pkg::cfg_type                     cfg
);

   bdpc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_pressed      <= bdpc_pkg::LOW_PRESSED_RESET;
         cfg_ff.debounce_ticks   <= bdpc_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.long_press_ticks <= bdpc_pkg::LONG_TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bdpc_pkg::CSR_LOW_PRESSED: begin
               cfg_ff.low_pressed <= csr_wdata[0];
            end
            bdpc_pkg::CSR_DEBOUNCE_TICKS: begin
               cfg_ff.debounce_ticks <= csr_wdata[7:0];
            end
            bdpc_pkg::CSR_LONG_TICKS: begin
               cfg_ff.long_press_ticks <= csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/bdpc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module bdpc_step #(
   parameter int SETTLE_BITS = 8,
   parameter int HOLD_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic                  opcode,
   input  wire logic                  pin_level,
   input  wire bdpc_pkg::cfg_type     cfg,
   output bdpc_pkg::press_event_type  press_event,
   output bdpc_pkg::hold_status_type  status
);

   localparam int DEB_W  = (SETTLE_BITS > 8) ? SETTLE_BITS : 8;
   localparam int LONG_W = (HOLD_BITS > 16) ? HOLD_BITS : 16;

   logic                   previous_level_ff, previous_level_in;
   logic [SETTLE_BITS-1:0] settle_count_ff, settle_count_in;
   logic [HOLD_BITS-1:0]   hold_count_ff, hold_count_in;
   logic                   is_held_ff, is_held_in;
   logic                   long_done_ff, long_done_in;

   logic                   pressed;
   logic [DEB_W-1:0]       deb_ext;
   logic [DEB_W-1:0]       settle_max_ext;
   logic [SETTLE_BITS-1:0] deb_sat;
   logic [SETTLE_BITS-1:0] settle_dec;
   logic [HOLD_BITS-1:0]   hold_next;
   logic [LONG_W-1:0]      hold_ext;
   logic [LONG_W-1:0]      long_ext;
   logic                   settled;

   assign pressed        = cfg.low_pressed ? ~pin_level : pin_level;
   assign deb_ext        = DEB_W'(cfg.debounce_ticks);
   assign settle_max_ext = DEB_W'({SETTLE_BITS{1'b1}});
   assign deb_sat        = (deb_ext > settle_max_ext) ? settle_max_ext[SETTLE_BITS-1:0]
                                                      : deb_ext[SETTLE_BITS-1:0];
   assign settle_dec     = settle_count_ff - SETTLE_BITS'(1);
   assign hold_next      = (hold_count_ff == {HOLD_BITS{1'b1}}) ? hold_count_ff
                                                                : hold_count_ff + HOLD_BITS'(1);
   assign hold_ext       = LONG_W'(hold_next);
   assign long_ext       = LONG_W'(cfg.long_press_ticks);

   always_comb begin
      previous_level_in = previous_level_ff;
      settle_count_in   = settle_count_ff;
      hold_count_in     = hold_count_ff;
      is_held_in        = is_held_ff;
      long_done_in      = long_done_ff;
      press_event       = bdpc_pkg::EV_NONE;
      settled           = 1'b1;
      if (opcode == bdpc_pkg::OP_SEED) begin
         previous_level_in = pin_level;
         settle_count_in   = '0;
         hold_count_in     = '0;
         is_held_in        = pressed;
         long_done_in      = pressed;
      end else if (pin_level != previous_level_ff) begin
         previous_level_in = pin_level;
         settle_count_in   = deb_sat;
      end else begin
         if (settle_count_ff != '0) begin
            settle_count_in = settle_dec;
            settled         = (settle_dec == '0);
         end
         if (settled) begin
            if (pressed && !is_held_ff) begin
               is_held_in    = 1'b1;
               hold_count_in = '0;
               long_done_in  = 1'b0;
            end else if (!pressed && is_held_ff) begin
               is_held_in = 1'b0;
               if (!long_done_ff) begin
                  press_event = bdpc_pkg::EV_SHORT;
               end
            end else if (pressed) begin
               hold_count_in = hold_next;
               if (!long_done_ff && (hold_ext >= long_ext)) begin
                  long_done_in = 1'b1;
                  press_event  = bdpc_pkg::EV_LONG;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_level_ff <= 1'b0;
         settle_count_ff   <= '0;
         hold_count_ff     <= '0;
         is_held_ff        <= 1'b0;
         long_done_ff      <= 1'b0;
      end else if (fire) begin
         previous_level_ff <= previous_level_in;
         settle_count_ff   <= settle_count_in;
         hold_count_ff     <= hold_count_in;
         is_held_ff        <= is_held_in;
         long_done_ff      <= long_done_in;
      end
   end

   assign status.is_held   = is_held_ff;
   assign status.long_done = long_done_ff;

endmodule

`default_nettype wire

>>> sv/button_debounce_press_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounces one sampled button level per beat and classifies presses. A seed beat
// records the starting level; a step beat restarts the settle countdown on a level
// change and, once the level has been stable for debounce_ticks samples, reports a
// short press on release or a long press when the hold reaches long_press_ticks.
// Every request beat produces exactly one response beat. The block takes one beat
// per cycle unless the response side stalls: a request is captured in an input
// register, then the settle and hold counters update and the event lands in the
// output register. Configuration writes belong in idle periods.
module button_debounce_press_classifier #(
   parameter int SETTLE_BITS = 8,
   parameter int HOLD_BITS   = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bdpc_req_if.sink                              req_bus,
   bdpc_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_wr_en,
   input  wire logic [bdpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bdpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bdpc_pkg::cfg_type         cfg;
   bdpc_pkg::press_event_type step_event;
   bdpc_pkg::hold_status_type status;

   logic       in_valid_ff;
   logic       in_opcode_ff;
   logic       in_level_ff;
   logic       out_valid_ff;
   logic [1:0] out_event_ff;
   logic       advance;
   logic       fire;
   logic       req_take;

   assign advance         = ~out_valid_ff | rsp_bus.ready;
   assign fire            = advance & in_valid_ff;
   assign req_bus.ready   = ~in_valid_ff | advance;
   assign req_take        = req_bus.valid & req_bus.ready;

   bdpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdpc_step #(
      .SETTLE_BITS (SETTLE_BITS),
      .HOLD_BITS   (HOLD_BITS)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .opcode      (in_opcode_ff),
      .pin_level   (in_level_ff),
      .cfg         (cfg),
      .press_event (step_event),
      .status      (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_bus.opcode;
         in_level_ff  <= req_bus.pin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_event_ff <= step_event;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.press_event = out_event_ff;

`ifndef NO_ASSERTIONS
   // A long press is only reported for a hold that is still in progress.
   a_long_while_held: assert property (@(posedge clock) disable iff (reset)
      fire && (step_event == bdpc_pkg::EV_LONG) |=> status.is_held && status.long_done)
      else $error("long press reported without an active hold");

   // A short press is only reported on the release that ends a hold.
   a_short_ends_hold: assert property (@(posedge clock) disable iff (reset)
      fire && (step_event == bdpc_pkg::EV_SHORT) |-> status.is_held && !status.long_done)
      else $error("short press reported outside a hold or after a long press");

   // Each accepted request beat reaches the output register within one advance.
   a_in_reaches_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed beat did not reach the output register");

   // A response beat never appears without a request beat behind it.
   a_no_spurious_out: assert property (@(posedge clock) disable iff (reset)
      advance && !in_valid_ff |=> !out_valid_ff)
      else $error("response beat produced without a request beat");
`endif

endmodule

`default_nettype wire
